FILE: rtl/spq_pkg.sv
package spq_pkg;

	// fixed field widths of the request and result items
	localparam int CMD_W            = 2;
	localparam int VALUE_W          = 32;
	localparam int PRI_FIELD_W      = 8;
	localparam int STATUS_W         = 2;

	// default build
	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_PRIORITY_BITS = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_RSVD  = 2'd3
	} status_t;

	// per-cycle move applied to every cell of the row
	typedef struct packed {
		logic push;   // insert new entry at its sorted place
		logic pop;    // shift everything one cell toward the head
	} cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell #(
	parameter int PRI_W = spq_pkg::PRI_FIELD_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::cell_ctrl_t         ctrl,
	input  logic [spq_pkg::VALUE_W-1:0] new_value,
	input  logic [PRI_W-1:0]            new_pri,
	input  logic                        left_keep,
	input  logic                        left_valid,
	input  logic [spq_pkg::VALUE_W-1:0] left_value,
	input  logic [PRI_W-1:0]            left_pri,
	input  logic                        right_valid,
	input  logic [spq_pkg::VALUE_W-1:0] right_value,
	input  logic [PRI_W-1:0]            right_pri,
	output logic                        keep,
	output logic                        valid,
	output logic [spq_pkg::VALUE_W-1:0] value,
	output logic [PRI_W-1:0]            pri
);

	logic                        valid_q;
	logic [spq_pkg::VALUE_W-1:0] value_q;
	logic [PRI_W-1:0]            pri_q;

	logic                        valid_d;
	logic [spq_pkg::VALUE_W-1:0] value_d;
	logic [PRI_W-1:0]            pri_d;

	// entry stays put on a push when it is served no later than the new one
	assign keep = valid_q && (pri_q <= new_pri);

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		pri_d   = pri_q;
		if (ctrl.push) begin
			if (!keep) begin
				if (left_keep) begin
					valid_d = 1'b1;
					value_d = new_value;
					pri_d   = new_pri;
				end else begin
					valid_d = left_valid;
					value_d = left_value;
					pri_d   = left_pri;
				end
			end
		end else if (ctrl.pop) begin
			valid_d = right_valid;
			value_d = right_value;
			pri_d   = right_pri;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		pri_q   <= pri_d;
	end

	assign valid = valid_q;
	assign value = value_q;
	assign pri   = pri_q;

endmodule

FILE: rtl/sorted_priority_queue.sv
// sorted priority queue built as a row of CAPACITY shift cells
// each result is registered; one request per cycle unless an unaccepted result
// blocks s_tready; every cell compares against the new priority
// at once, so a push or pop is a single parallel shift of the whole row
// reset: arst_n clears all cell valid bits (queue empty) and the result valid flag
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [39:32] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] head_value
	output logic [1:0]  m_tuser    // [1:0] status
);

	// priorities above the 8-bit field are always zero, so store no more bits
	localparam int PRI_W = (PRIORITY_BITS < spq_pkg::PRI_FIELD_W) ?
		PRIORITY_BITS : spq_pkg::PRI_FIELD_W;

	// request fields
	spq_pkg::cmd_t               req_cmd;
	logic [spq_pkg::VALUE_W-1:0] req_value;
	logic [PRI_W-1:0]            req_pri;   // masked to PRIORITY_BITS by the select

	assign req_cmd   = spq_pkg::cmd_t'(s_tuser);
	assign req_value = s_tdata[spq_pkg::VALUE_W-1:0];
	assign req_pri   = s_tdata[spq_pkg::VALUE_W +: PRI_W];

	// cell row, index 0 is the head
	logic                        cell_keep  [CAPACITY];
	logic                        cell_valid [CAPACITY];
	logic [spq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
	logic [PRI_W-1:0]            cell_pri   [CAPACITY];
	logic [CAPACITY-1:0]         valid_vec;

	logic                req_fire;
	logic                q_empty;
	logic                q_full;
	spq_pkg::cell_ctrl_t ctrl;

	// result register
	logic                        m_valid_q;
	logic [spq_pkg::VALUE_W-1:0] head_q;
	spq_pkg::status_t            status_q;

	logic [spq_pkg::VALUE_W-1:0] head_d;
	spq_pkg::status_t            status_d;

	// a new request is taken whenever the result register is free or draining
	assign s_tready = !m_valid_q || m_tready;
	assign req_fire = s_tvalid && s_tready;

	// valid bits stay packed toward the head, so the ends give empty and full
	assign q_empty = !cell_valid[0];
	assign q_full  = cell_valid[CAPACITY-1];

	assign ctrl.push = req_fire && (req_cmd == spq_pkg::CMD_PUSH) && !q_full;
	assign ctrl.pop  = req_fire && (req_cmd == spq_pkg::CMD_POP) && !q_empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                        l_keep;
		logic                        l_valid;
		logic [spq_pkg::VALUE_W-1:0] l_value;
		logic [PRI_W-1:0]            l_pri;
		logic                        r_valid;
		logic [spq_pkg::VALUE_W-1:0] r_value;
		logic [PRI_W-1:0]            r_pri;

		if (i == 0) begin : g_head
			// head cell takes the new entry unless it keeps its own
			assign l_keep  = 1'b1;
			assign l_valid = 1'b0;
			assign l_value = '0;
			assign l_pri   = '0;
		end else begin : g_mid
			assign l_keep  = cell_keep[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_value = cell_value[i-1];
			assign l_pri   = cell_pri[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// tail cell empties on a pop
			assign r_valid = 1'b0;
			assign r_value = '0;
			assign r_pri   = '0;
		end else begin : g_body
			assign r_valid = cell_valid[i+1];
			assign r_value = cell_value[i+1];
			assign r_pri   = cell_pri[i+1];
		end

		spq_cell #(
			.PRI_W (PRI_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (req_value),
			.new_pri     (req_pri),
			.left_keep   (l_keep),
			.left_valid  (l_valid),
			.left_value  (l_value),
			.left_pri    (l_pri),
			.right_valid (r_valid),
			.right_value (r_value),
			.right_pri   (r_pri),
			.keep        (cell_keep[i]),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.pri         (cell_pri[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	// result of the request being taken this cycle
	always_comb begin
		head_d   = '0;
		status_d = spq_pkg::STATUS_DONE;
		case (req_cmd)
			spq_pkg::CMD_PUSH: begin
				if (q_full) begin
					status_d = spq_pkg::STATUS_FULL;
				end
			end
			spq_pkg::CMD_POP, spq_pkg::CMD_PEEK: begin
				if (q_empty) begin
					status_d = spq_pkg::STATUS_EMPTY;
				end else begin
					head_d = cell_value[0];
				end
			end
			default: begin
				// unused command leaves the queue alone and reports done
				status_d = spq_pkg::STATUS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			head_q   <= head_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = head_q;
	assign m_tuser  = status_q;

	// adjacent entries must be in service order
	logic order_ok;
	always_comb begin
		order_ok = 1'b1;
		for (int k = 1; k < CAPACITY; k++) begin
			if (cell_valid[k] && (cell_pri[k] < cell_pri[k-1])) begin
				order_ok = 1'b0;
			end
		end
	end

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec[CAPACITY-1:1] & ~valid_vec[CAPACITY-2:0]) == '0)
		else $error("cell valid bits not packed toward the head");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		order_ok)
		else $error("stored priorities out of order");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req_cmd == spq_pkg::CMD_PUSH) && q_full
		|=> (m_tuser == spq_pkg::STATUS_FULL) && $stable(valid_vec))
		else $error("refused push changed the queue or lost full status");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> ($countones(valid_vec) == $countones($past(valid_vec)) - 1))
		else $error("pop did not remove exactly one entry");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
		else $error("push did not add exactly one entry");

endmodule

FILE: tb/spq_checker.sv
`timescale 1ns / 1ps
module spq_checker #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [39:32] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] head_value
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          fail_count,
	output int          open_results
);

	typedef struct packed {
		logic [31:0]       head;
		spq_pkg::status_t  status;
	} head_result_t;

	localparam logic [31:0] PRI_MASK =
		(PRIORITY_BITS >= 32) ? 32'hffff_ffff : ((32'd1 << PRIORITY_BITS) - 32'd1);

	// shadow copy of the sorted row, head at index 0
	logic [31:0]  held_value [CAPACITY];
	logic [7:0]   held_pri   [CAPACITY];
	int           held_count;

	head_result_t awaited_results [$];
	int           errors;
	int           result_index;

	assign fail_count   = errors;
	assign open_results = awaited_results.size();

	function automatic head_result_t serve_request(spq_pkg::cmd_t op, logic [31:0] v,
			logic [7:0] p);
		head_result_t r;
		int           pos;
		logic [7:0]   pm;
		r.head   = '0;
		r.status = spq_pkg::STATUS_DONE;
		pm       = p & PRI_MASK[7:0];
		case (op)
			spq_pkg::CMD_PUSH: begin
				if (held_count >= CAPACITY) begin
					r.status = spq_pkg::STATUS_FULL;
				end else begin
					// new entry goes behind every entry of equal or better priority
					pos = 0;
					while (pos < held_count && held_pri[pos] <= pm)
						pos++;
					for (int i = held_count; i > pos; i--) begin
						held_value[i] = held_value[i-1];
						held_pri[i]   = held_pri[i-1];
					end
					held_value[pos] = v;
					held_pri[pos]   = pm;
					held_count++;
				end
			end
			spq_pkg::CMD_POP, spq_pkg::CMD_PEEK: begin
				if (held_count == 0) begin
					r.status = spq_pkg::STATUS_EMPTY;
				end else begin
					r.head = held_value[0];
					if (op == spq_pkg::CMD_POP) begin
						for (int i = 1; i < held_count; i++) begin
							held_value[i-1] = held_value[i];
							held_pri[i-1]   = held_pri[i];
						end
						held_count--;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		head_result_t want;
		if (!arst_n) begin
			held_count   = 0;
			errors       = 0;
			result_index = 0;
			awaited_results.delete();
		end else begin
			// a result is registered and leaves after its request is taken, so retire first
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					if (errors < 10)
						$display("result %0d: no request pending, got value %h status %0d",
							result_index, m_tdata, m_tuser);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata !== want.head || m_tuser !== want.status) begin
						if (errors < 10)
							$display("result %0d: expected value %h status %0d, got value %h status %0d",
								result_index, want.head, want.status, m_tdata, m_tuser);
						errors++;
					end
				end
				result_index++;
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(serve_request(spq_pkg::cmd_t'(s_tuser),
					s_tdata[31:0], s_tdata[39:32]));
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int          RANDOM_ITEMS = 1470;
	// last stretch of the random part runs with no idling on either side
	localparam int          CALM_TAIL    = 150;
	// worst case is far below this even with every gap and stall at its longest
	localparam int unsigned CYCLE_LIMIT  = 400_000;

	typedef enum {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} traffic_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // [31:0] value, [39:32] priority_req
	logic [1:0]  s_tuser;    // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] head_value
	logic [1:0]  m_tuser;    // [1:0] status

	int          fail_count;
	int          open_results;
	int          gap_pct   = 0;
	int          stall_pct = 0;
	int unsigned cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sorted_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spq_checker order_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side backpressure: random stall bursts
	initial begin
		m_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// drive one request, after an optional random gap, and hold it until the queue takes it
	task automatic send(input spq_pkg::cmd_t op, input logic [31:0] v, input logic [7:0] p);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {p, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold off new requests until every result is back
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (open_results == 0);
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0:       return 32'h7fff_ffff;
				1:       return 32'h8000_0000;
				2:       return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	// a narrow range makes equal priorities common, so arrival order gets exercised
	function automatic logic [7:0] rand_priority();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 3));
			1:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// fill runs into the full refusal, drain runs into the empty report
	function automatic spq_pkg::cmd_t pick_op(traffic_mode_t mode);
		int r;
		int push_lim;
		int pop_lim;
		int peek_lim;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				push_lim = 85; pop_lim = 93; peek_lim = 98;
			end
			MODE_DRAIN: begin
				push_lim = 15; pop_lim = 80; peek_lim = 95;
			end
			default: begin
				push_lim = 45; pop_lim = 80; peek_lim = 95;
			end
		endcase
		if (r < push_lim)
			return spq_pkg::CMD_PUSH;
		else if (r < pop_lim)
			return spq_pkg::CMD_POP;
		else if (r < peek_lim)
			return spq_pkg::CMD_PEEK;
		return spq_pkg::CMD_UNUSED;
	endfunction

	initial begin : stimulus
		traffic_mode_t mode;
		spq_pkg::cmd_t op;
		int            real_items;
		int            seg_len;
		bit            pressure_done;
		logic [7:0]    pr;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = spq_pkg::CMD_PUSH;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, with light idling on both sides
		gap_pct   = 20;
		stall_pct = 20;
		// pop and peek of an empty queue, then the unused command with all data bits set
		send(spq_pkg::CMD_POP,    32'hffff_ffff, 8'hff);
		send(spq_pkg::CMD_PEEK,   32'h0000_0000, 8'h00);
		send(spq_pkg::CMD_UNUSED, 32'hffff_ffff, 8'hff);
		// value extremes at priority extremes, with a tie at the best priority
		send(spq_pkg::CMD_PUSH,   32'h7fff_ffff, 8'hff);
		send(spq_pkg::CMD_PUSH,   32'h8000_0000, 8'h00);
		send(spq_pkg::CMD_PUSH,   32'h0000_0000, 8'h00);
		send(spq_pkg::CMD_PUSH,   32'hffff_ffff, 8'h80);
		send(spq_pkg::CMD_PEEK,   32'h5555_5555, 8'haa);
		// fill up to capacity with a mix of ties and extremes
		for (int i = 0; i < 12; i++) begin
			pr = (i % 4 == 3) ? 8'hff : 8'(i % 3);
			send(spq_pkg::CMD_PUSH, $urandom, pr);
		end
		// one past capacity is refused
		send(spq_pkg::CMD_PUSH,   32'h1234_5678, 8'h00);
		send(spq_pkg::CMD_PEEK,   32'haaaa_aaaa, 8'h55);
		send(spq_pkg::CMD_POP,    32'h0000_0000, 8'h00);
		send(spq_pkg::CMD_POP,    32'h0000_0000, 8'h00);
		send(spq_pkg::CMD_UNUSED, 32'h0000_0000, 8'h00);
		drain_pause();

		// random part in segments of one traffic mode each
		real_items    = 0;
		pressure_done = 1'b0;
		while (real_items < RANDOM_ITEMS) begin
			mode    = traffic_mode_t'($urandom_range(0, 2));
			seg_len = $urandom_range(10, 60);
			if (real_items >= RANDOM_ITEMS - CALM_TAIL) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			if (!pressure_done && real_items >= RANDOM_ITEMS / 2) begin
				drain_pause();
				pressure_done = 1'b1;
			end
			repeat (seg_len) begin
				op = pick_op(mode);
				send(op, rand_value(), rand_priority());
				// the unused command is ignored by the queue and does not count
				if (op != spq_pkg::CMD_UNUSED)
					real_items++;
			end
		end

		// wait out the outstanding results before the final report
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (open_results == 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
